// ----- rtl/core/crm_pkg.sv -----
// Package for the Catmull-Rom interpolator: formats, derived widths and transaction types.
`default_nettype none

package crm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;

  // Parameter s is unsigned with one integer bit so that one itself is representable.
  localparam int S_W = FRAC_BITS + 1;

  // The polynomial coefficients are at most twelve times a coordinate in magnitude.
  localparam int K_W = COORD_BITS + 4;

  // Horner accumulator widths, each wide enough that no step can wrap.
  localparam int P3_W = K_W + S_W + 1;
  localparam int A1_W = P3_W + 1;
  localparam int L1_W = A1_W / 2;
  localparam int H1_W = A1_W - L1_W;
  localparam int A2_W = A1_W + S_W + 1;
  localparam int L2_W = A2_W / 2;
  localparam int H2_W = A2_W - L2_W;
  localparam int A3_W = A2_W + S_W + 1;

  // Halving plus three factors of s are removed in one arithmetic shift.
  localparam int R_SH = 3 * FRAC_BITS + 1;
  localparam int R_W  = A3_W - R_SH;

  localparam int PIPE_DEPTH = 8;

  localparam logic [S_W-1:0] ONE_S = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic        [S_W-1:0]        param_s;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         saturated;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] value;
    logic                         sat;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/crm_lane.sv -----
// One coordinate of the spline: coefficient build, Horner multiply-add chain and saturation.
`default_nettype none

module crm_lane import crm_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] q0,
  input  logic signed [COORD_BITS-1:0] q1,
  input  logic signed [COORD_BITS-1:0] q2,
  input  logic signed [COORD_BITS-1:0] q3,
  input  logic        [S_W-1:0]        s,
  output lane_res_t                    res
);

  // Stage 1: coefficients.
  logic signed [K_W-1:0] k0_a, k1_a, k2_a, k3_a;
  logic        [S_W-1:0] s_a;
  // Stage 2: k3 * s.
  logic signed [P3_W-1:0] p3_b;
  logic signed [K_W-1:0]  k0_b, k1_b, k2_b;
  logic        [S_W-1:0]  s_b;
  // Stage 3: first Horner sum.
  logic signed [A1_W-1:0] a1_c;
  logic signed [K_W-1:0]  k0_c, k1_c;
  logic        [S_W-1:0]  s_c;
  // Stage 4: split product of the first sum.
  logic        [L1_W+S_W-1:0] lo1_d;
  logic signed [H1_W+S_W:0]   hi1_d;
  logic signed [K_W-1:0]      k0_d, k1_d;
  logic        [S_W-1:0]      s_d;
  // Stage 5: second Horner sum.
  logic signed [A2_W-1:0] a2_e;
  logic signed [K_W-1:0]  k0_e;
  logic        [S_W-1:0]  s_e;
  // Stage 6: split product of the second sum.
  logic        [L2_W+S_W-1:0] lo2_f;
  logic signed [H2_W+S_W:0]   hi2_f;
  logic signed [K_W-1:0]      k0_f;
  // Stage 7: final sum.
  logic signed [A3_W-1:0] a3_g;

  logic signed [K_W-1:0] k0_next, k1_next, k2_next, k3_next;
  lane_res_t             res_next;

  always_comb begin
    logic signed [K_W-1:0] e0, e1, e2, e3, d12;
    e0 = K_W'(q0);
    e1 = K_W'(q1);
    e2 = K_W'(q2);
    e3 = K_W'(q3);
    d12 = e1 - e2;
    k0_next = e1 <<< 1;
    k1_next = e2 - e0;
    k2_next = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    k3_next = (e3 - e0) + ((d12 <<< 1) + d12);
  end

  always_comb begin
    logic [R_W-1:0] r;
    logic           in_range;
    r = a3_g[A3_W-1:R_SH];
    in_range = (&r[R_W-1:COORD_BITS-1]) | ~(|r[R_W-1:COORD_BITS-1]);
    res_next.sat = ~in_range;
    if (in_range) begin
      res_next.value = $signed(r[COORD_BITS-1:0]);
    end else if (r[R_W-1]) begin
      res_next.value = COORD_MIN;
    end else begin
      res_next.value = COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0_a <= k0_next;
      k1_a <= k1_next;
      k2_a <= k2_next;
      k3_a <= k3_next;
      s_a  <= s;

      p3_b <= k3_a * $signed({1'b0, s_a});
      k0_b <= k0_a;
      k1_b <= k1_a;
      k2_b <= k2_a;
      s_b  <= s_a;

      a1_c <= A1_W'(p3_b) + (A1_W'(k2_b) <<< FRAC_BITS);
      k0_c <= k0_b;
      k1_c <= k1_b;
      s_c  <= s_b;

      // The wide sum is multiplied in two halves to keep each multiplier narrow.
      lo1_d <= a1_c[L1_W-1:0] * s_c;
      hi1_d <= $signed(a1_c[A1_W-1:L1_W]) * $signed({1'b0, s_c});
      k0_d  <= k0_c;
      k1_d  <= k1_c;
      s_d   <= s_c;

      a2_e <= (A2_W'(hi1_d) <<< L1_W) + A2_W'({1'b0, lo1_d})
              + (A2_W'(k1_d) <<< (2 * FRAC_BITS));
      k0_e <= k0_d;
      s_e  <= s_d;

      lo2_f <= a2_e[L2_W-1:0] * s_e;
      hi2_f <= $signed(a2_e[A2_W-1:L2_W]) * $signed({1'b0, s_e});
      k0_f  <= k0_e;

      a3_g <= (A3_W'(hi2_f) <<< L2_W) + A3_W'({1'b0, lo2_f})
              + (A3_W'(k0_f) <<< (3 * FRAC_BITS));

      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/catmull_rom_interp_2d_top.sv -----
// Top level: input handshake, parameter clamp, two coordinate lanes and the valid chain.
// Throughput: one transaction per cycle unless the output stalls; the eight-stage multiply-add chain of each lane
// accepts a new point every cycle in which the output is not stalled.
// A stall at the output freezes every stage, so nothing is dropped or repeated.
// Reset clears only the stage valid bits; the data registers carry no reset.
`default_nettype none

module catmull_rom_interp_2d_top import crm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;
  logic [S_W-1:0]        s_clamped;
  lane_res_t             res_x, res_y;

  assign en           = ~vld[PIPE_DEPTH-1] | result_ready;
  assign item_ready   = en;
  assign result_valid = vld[PIPE_DEPTH-1];

  // A parameter beyond one is taken as exactly one.
  assign s_clamped = (item.param_s > ONE_S) ? ONE_S : item.param_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], item_valid};
    end
  end

  crm_lane u_lane_x (
    .clk (clk),
    .en  (en),
    .q0  (item.p0_x),
    .q1  (item.p1_x),
    .q2  (item.p2_x),
    .q3  (item.p3_x),
    .s   (s_clamped),
    .res (res_x)
  );

  crm_lane u_lane_y (
    .clk (clk),
    .en  (en),
    .q0  (item.p0_y),
    .q1  (item.p1_y),
    .q2  (item.p2_y),
    .q3  (item.p3_y),
    .s   (s_clamped),
    .res (res_y)
  );

  always_comb begin
    result.out_x     = res_x.value;
    result.out_y     = res_y.value;
    result.saturated = res_x.sat | res_y.sat;
  end

  // An accepted transaction must occupy the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> vld[0])
    else $error("accepted transaction missing from first stage");

  // A stalled output holds the whole valid chain.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(vld))
    else $error("valid chain moved during a stall");

  // A saturated result has at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.out_x == COORD_MAX || result.out_x == COORD_MIN ||
       result.out_y == COORD_MAX || result.out_y == COORD_MIN))
    else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire
